// ===== hdl/slbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the serial-loaded bank mapper.
// No dependencies; every other file in hdl/ but slbm_ram.sv refers to this package by scoped name.
package slbm_pkg;

    // Work RAM geometry
    localparam int RAM_DEPTH = 8192;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int RAM_DW    = 8;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Serial load register
    localparam int SHIFT_LEN = 5;

    // Access kinds on the input channel
    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_RAM_READ  = 2'd1;
    localparam logic [1:0] KIND_RAM_WRITE = 2'd2;

    // Register select (address bits 14:13)
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    // PRG bank modes (control bits 3:2)
    localparam logic [1:0] PRG_MODE_32K_A  = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B  = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_LO = 2'd2;

    localparam logic [4:0] CTRL_RESET     = 5'h0c;
    localparam logic [4:0] CTRL_PRG_MODE3 = 5'h0c;

    // Operation carried from front to back
    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE,
        OP_REG
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
        logic              ignored;
        logic [1:0]        mirroring;
        logic [3:0]        prg_bank_8000;
        logic [3:0]        prg_bank_c000;
        logic [4:0]        chr_bank_0000;
        logic [4:0]        chr_bank_1000;
    } t_qent;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ram_served;
        logic       write_ignored;
        logic [1:0] mirroring;
        logic [3:0] prg_bank_8000;
        logic [3:0] prg_bank_c000;
        logic [4:0] chr_bank_0000;
        logic [4:0] chr_bank_1000;
    } t_res;

endpackage

// ===== hdl/slbm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module slbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/slbm_front.sv =====
`timescale 1ns / 1ps
// Front end: serial register load, write spacing check, bank mapping, access classing.
// Depends on slbm_pkg.
module slbm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [1:0]          i_kind,
    input  logic [15:0]         i_address,
    input  logic [7:0]          i_data,
    input  logic [31:0]         i_cycle,
    input  logic                i_cfg_we,
    input  logic                i_cfg_chr_rom,
    output slbm_pkg::t_qent     o_entry
);

    logic [4:0]  r_shift, n_shift;
    logic [2:0]  r_count, n_count;
    logic [4:0]  r_control, n_control;
    logic [4:0]  r_chr_low, n_chr_low;
    logic [4:0]  r_chr_high, n_chr_high;
    logic [4:0]  r_prg, n_prg;
    logic [31:0] r_last, n_last;
    logic        r_chr_rom;

    logic [31:0] gap;
    logic        too_close;
    logic        is_reg;
    logic [4:0]  sh_add;
    logic [3:0]  pb;
    logic        ram_on;

    always_comb begin
        n_shift    = r_shift;
        n_count    = r_count;
        n_control  = r_control;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;
        n_prg      = r_prg;
        n_last     = r_last;
        gap        = i_cycle - r_last;
        too_close  = (gap[31:1] == 31'd0);
        is_reg     = (i_kind == slbm_pkg::KIND_REG_WRITE);
        sh_add     = r_shift | (5'(i_data[0]) << r_count);
        if (i_push && is_reg) begin
            n_last = i_cycle;
            if (!too_close) begin
                if (i_data[7]) begin
                    n_shift   = 5'd0;
                    n_count   = 3'd0;
                    n_control = r_control | slbm_pkg::CTRL_PRG_MODE3;
                end else if (r_count == 3'(slbm_pkg::SHIFT_LEN - 1)) begin
                    n_shift = 5'd0;
                    n_count = 3'd0;
                    case (i_address[14:13])
                        slbm_pkg::SEL_CONTROL:  n_control  = sh_add;
                        slbm_pkg::SEL_CHR_LOW:  n_chr_low  = sh_add;
                        slbm_pkg::SEL_CHR_HIGH: n_chr_high = sh_add;
                        default:                n_prg      = sh_add;
                    endcase
                end else begin
                    n_shift = sh_add;
                    n_count = r_count + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= 5'd0;
            r_count    <= 3'd0;
            r_control  <= slbm_pkg::CTRL_RESET;
            r_chr_low  <= 5'd0;
            r_chr_high <= 5'd0;
            r_prg      <= 5'd0;
            r_last     <= 32'd0;
            r_chr_rom  <= 1'b1;
        end else begin
            r_shift    <= n_shift;
            r_count    <= n_count;
            r_control  <= n_control;
            r_chr_low  <= n_chr_low;
            r_chr_high <= n_chr_high;
            r_prg      <= n_prg;
            r_last     <= n_last;
            if (i_cfg_we) begin
                r_chr_rom <= i_cfg_chr_rom;
            end
        end
    end

    // Entry for the back end; mapping reflects the state after this transaction.
    always_comb begin
        ram_on          = !r_prg[4];
        pb              = n_prg[3:0];
        o_entry         = '0;
        o_entry.addr    = i_address[slbm_pkg::RAM_AW-1:0];
        o_entry.data    = i_data;
        o_entry.ignored = is_reg && too_close;
        case (i_kind)
            slbm_pkg::KIND_REG_WRITE: o_entry.op = slbm_pkg::OP_REG;
            slbm_pkg::KIND_RAM_READ:  o_entry.op = ram_on ? slbm_pkg::OP_READ
                                                          : slbm_pkg::OP_NONE;
            slbm_pkg::KIND_RAM_WRITE: o_entry.op = ram_on ? slbm_pkg::OP_WRITE
                                                          : slbm_pkg::OP_NONE;
            default:                  o_entry.op = slbm_pkg::OP_NONE;
        endcase
        o_entry.mirroring = n_control[1:0];
        case (n_control[3:2])
            slbm_pkg::PRG_MODE_32K_A, slbm_pkg::PRG_MODE_32K_B: begin
                o_entry.prg_bank_8000 = {pb[3:1], 1'b0};
                o_entry.prg_bank_c000 = {pb[3:1], 1'b1};
            end
            slbm_pkg::PRG_MODE_FIX_LO: begin
                o_entry.prg_bank_8000 = 4'd0;
                o_entry.prg_bank_c000 = pb;
            end
            default: begin
                o_entry.prg_bank_8000 = pb;
                o_entry.prg_bank_c000 = 4'hf;
            end
        endcase
        if (!r_chr_rom) begin
            o_entry.chr_bank_0000 = 5'd0;
            o_entry.chr_bank_1000 = 5'd1;
        end else if (n_control[4]) begin
            o_entry.chr_bank_0000 = n_chr_low;
            o_entry.chr_bank_1000 = n_chr_high;
        end else begin
            o_entry.chr_bank_0000 = {n_chr_low[4:1], 1'b0};
            o_entry.chr_bank_1000 = {n_chr_low[4:1], 1'b1};
        end
    end

    a_ignored_keeps_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && is_reg && too_close |=>
            $stable(r_shift) && $stable(r_count) && $stable(r_control) && $stable(r_prg))
        else $error("ignored register write changed mapper state");

endmodule

// ===== hdl/slbm_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified transactions between front and back ends.
// Depends on slbm_pkg.
module slbm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slbm_pkg::t_qent i_data,
    input  logic            i_pop,
    output slbm_pkg::t_qent o_data,
    output logic            o_full,
    output logic            o_empty
);

    slbm_pkg::t_qent                 r_slot [slbm_pkg::QUEUE_DEPTH];
    logic [slbm_pkg::QUEUE_PW-1:0]   r_wptr, r_rptr;
    logic [slbm_pkg::QUEUE_CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == slbm_pkg::QUEUE_PW'(slbm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == slbm_pkg::QUEUE_PW'(slbm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_slot[r_rptr];
    assign o_full  = (r_count == slbm_pkg::QUEUE_CW'(slbm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full && !i_pop) == 1'b0 && (i_pop && o_empty) == 1'b0)
        else $error("queue pushed when full or popped when empty");

endmodule

// ===== hdl/slbm_back.sv =====
`timescale 1ns / 1ps
// Back end: work RAM clearing pass, RAM access, result register.
// Depends on slbm_pkg and slbm_ram.
module slbm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  slbm_pkg::t_qent i_q_data,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output slbm_pkg::t_res  o_res
);

    logic                          r_clearing;
    logic [slbm_pkg::RAM_AW-1:0]   r_clr_addr;
    logic                          r_b2_valid;
    slbm_pkg::t_qent               r_b2;
    logic                          r_o_valid;
    slbm_pkg::t_res                r_out;

    logic                          b2_adv;
    logic                          pop;
    logic                          ram_we;
    logic                          ram_re;
    logic [slbm_pkg::RAM_AW-1:0]   ram_waddr;
    logic [slbm_pkg::RAM_DW-1:0]   ram_wdata;
    logic [slbm_pkg::RAM_DW-1:0]   ram_rdata;

    assign b2_adv = r_b2_valid && (!r_o_valid || !i_out_stall);
    assign pop    = !r_clearing && !i_q_empty && (!r_b2_valid || b2_adv);

    always_comb begin
        ram_we    = r_clearing || (pop && i_q_data.op == slbm_pkg::OP_WRITE);
        ram_waddr = r_clearing ? r_clr_addr : i_q_data.addr;
        ram_wdata = r_clearing ? '0 : i_q_data.data;
        ram_re    = pop && i_q_data.op == slbm_pkg::OP_READ;
    end

    slbm_ram #(
        .WIDTH (slbm_pkg::RAM_DW),
        .DEPTH (slbm_pkg::RAM_DEPTH)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_q_data.addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {slbm_pkg::RAM_AW{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            if (pop) begin
                r_b2_valid <= 1'b1;
            end else if (b2_adv) begin
                r_b2_valid <= 1'b0;
            end
            if (b2_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        if (pop) begin
            r_b2 <= i_q_data;
        end
        if (b2_adv) begin
            r_out.read_data     <= (r_b2.op == slbm_pkg::OP_READ) ? ram_rdata : 8'd0;
            r_out.ram_served    <= (r_b2.op == slbm_pkg::OP_READ) ||
                                   (r_b2.op == slbm_pkg::OP_WRITE);
            r_out.write_ignored <= r_b2.ignored;
            r_out.mirroring     <= r_b2.mirroring;
            r_out.prg_bank_8000 <= r_b2.prg_bank_8000;
            r_out.prg_bank_c000 <= r_b2.prg_bank_c000;
            r_out.chr_bank_0000 <= r_b2.chr_bank_0000;
            r_out.chr_bank_1000 <= r_b2.chr_bank_1000;
        end
    end

    assign o_q_pop     = pop;
    assign o_clearing  = r_clearing;
    assign o_out_valid = r_o_valid;
    assign o_res       = r_out;

    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !pop)
        else $error("transaction popped during RAM clearing pass");

    a_b2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_valid && !b2_adv |=> r_b2_valid && $stable(r_b2))
        else $error("stalled access stage lost its transaction");

    a_data_only_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_out.read_data != 8'd0 |-> r_out.ram_served)
        else $error("read data returned for an unserved transaction");

endmodule

// ===== hdl/serial_loaded_bank_mapper_core.sv =====
`timescale 1ns / 1ps
// Serial-loaded bank mapper top level; uses slbm_pkg, slbm_front, slbm_queue, slbm_back, slbm_ram.
// An accepted transaction passes a queue slot, stage r_b2 and register r_out to o_out_valid.
// Throughput: one transaction per clock unless a stall holds it; every stage moves one a cycle
// and each makes at most one work RAM access. Output stalls back up through the 4-entry queue
// before o_in_stall rises. Reset (i_rst_n low, synchronous) restores the mapper registers, then
// a clearing pass zeroes all 8192 work RAM bytes one byte a cycle with o_in_stall high.
module serial_loaded_bank_mapper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input transaction channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [31:0] i_cycle,

    // Configuration write channel (CHR ROM fitted flag)
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_chr_rom,

    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_ram_served,
    output logic        o_write_ignored,
    output logic [1:0]  o_mirroring,
    output logic [3:0]  o_prg_bank_8000,
    output logic [3:0]  o_prg_bank_c000,
    output logic [4:0]  o_chr_bank_0000,
    output logic [4:0]  o_chr_bank_1000
);

    // Front end updates the serial load state and the bank registers at acceptance and
    // pushes a classified transaction; the back end owns the work RAM.
    slbm_pkg::t_qent front_entry;
    slbm_pkg::t_qent q_head;
    slbm_pkg::t_res  res;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            clearing;
    logic            in_accept;

    // The config register can always be written; only the front end holds it.
    assign o_cfg_ready = 1'b1;

    // Hold off input while the queue is full or the RAM is still being cleared.
    assign o_in_stall = q_full || clearing;
    assign in_accept  = i_in_valid && !o_in_stall;

    slbm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (in_accept),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_cycle       (i_cycle),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_chr_rom (i_cfg_chr_rom),
        .o_entry       (front_entry)
    );

    // Decouples the two halves so an output stall does not ripple straight to the input.
    slbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_entry),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    slbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_head),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_read_data     = res.read_data;
    assign o_ram_served    = res.ram_served;
    assign o_write_ignored = res.write_ignored;
    assign o_mirroring     = res.mirroring;
    assign o_prg_bank_8000 = res.prg_bank_8000;
    assign o_prg_bank_c000 = res.prg_bank_c000;
    assign o_chr_bank_0000 = res.chr_bank_0000;
    assign o_chr_bank_1000 = res.chr_bank_1000;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for serial_loaded_bank_mapper_core: queue-fed driver, clocked monitor,
// and a transaction-level predictor of the mapper registers, bank mapping and work RAM.
// Depends on slbm_pkg and the RTL under hdl/.
module tb;

    // Access kind that the mapper leaves alone
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MIX_TARGET  = 445;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [31:0] cyc;
    } t_access;

    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind             = '0;
    logic [15:0] i_address          = '0;
    logic [7:0]  i_data             = '0;
    logic [31:0] i_cycle            = '0;
    logic        i_cfg_valid        = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_chr_rom      = 1'b1;
    logic        o_out_valid;
    logic        i_out_stall        = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_ram_served;
    logic        o_write_ignored;
    logic [1:0]  o_mirroring;
    logic [3:0]  o_prg_bank_8000;
    logic [3:0]  o_prg_bank_c000;
    logic [4:0]  o_chr_bank_0000;
    logic [4:0]  o_chr_bank_1000;

    serial_loaded_bank_mapper_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_address         (i_address),
        .i_data            (i_data),
        .i_cycle           (i_cycle),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_chr_rom     (i_cfg_chr_rom),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_read_data       (o_read_data),
        .o_ram_served      (o_ram_served),
        .o_write_ignored   (o_write_ignored),
        .o_mirroring       (o_mirroring),
        .o_prg_bank_8000   (o_prg_bank_8000),
        .o_prg_bank_c000   (o_prg_bank_c000),
        .o_chr_bank_0000   (o_chr_bank_0000),
        .o_chr_bank_1000   (o_chr_bank_1000)
    );

    // Predicted mapper state
    logic [4:0]  shift_q        = '0;
    logic [2:0]  shift_cnt      = '0;
    logic [4:0]  control_q      = slbm_pkg::CTRL_RESET;
    logic [4:0]  chr_low_q      = '0;
    logic [4:0]  chr_high_q     = '0;
    logic [4:0]  prg_q          = '0;
    logic [31:0] last_reg_cycle = '0;
    logic        chr_rom_fitted = 1'b1;
    logic [7:0]  ram_image [slbm_pkg::RAM_DEPTH];

    // Stimulus and scoreboard bookkeeping
    t_access         pending_acc [$];
    slbm_pkg::t_res  expected_res [$];
    t_access         on_bus;
    logic [31:0]     cpu_cycle     = '0;
    int              items_queued  = 0;
    int              results_seen  = 0;
    int              fault_count   = 0;
    int              tick_count    = 0;
    int              send_idle_pct = 0;
    int              out_stall_pct = 0;
    logic            long_hold     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // One CPU bus access through the mapper; updates the predicted state
    function automatic slbm_pkg::t_res map_access(input t_access acc);
        slbm_pkg::t_res r;
        logic           ram_on;
        logic [31:0]    gap;
        logic [3:0]     pb;
        r      = '0;
        ram_on = !prg_q[4];
        case (acc.kind)
            slbm_pkg::KIND_REG_WRITE: begin
                gap            = acc.cyc - last_reg_cycle;
                last_reg_cycle = acc.cyc;
                if (gap <= 32'd1) begin
                    r.write_ignored = 1'b1;
                end else if (acc.data[7]) begin
                    shift_q   = '0;
                    shift_cnt = '0;
                    control_q = control_q | slbm_pkg::CTRL_PRG_MODE3;
                end else begin
                    shift_q[shift_cnt] = acc.data[0];
                    shift_cnt          = shift_cnt + 3'd1;
                    if (shift_cnt == 3'(slbm_pkg::SHIFT_LEN)) begin
                        case (acc.addr[14:13])
                            slbm_pkg::SEL_CONTROL:  control_q  = shift_q;
                            slbm_pkg::SEL_CHR_LOW:  chr_low_q  = shift_q;
                            slbm_pkg::SEL_CHR_HIGH: chr_high_q = shift_q;
                            default:                prg_q      = shift_q;
                        endcase
                        shift_q   = '0;
                        shift_cnt = '0;
                    end
                end
            end
            slbm_pkg::KIND_RAM_READ: begin
                if (ram_on) begin
                    r.read_data  = ram_image[acc.addr[slbm_pkg::RAM_AW-1:0]];
                    r.ram_served = 1'b1;
                end
            end
            slbm_pkg::KIND_RAM_WRITE: begin
                if (ram_on) begin
                    ram_image[acc.addr[slbm_pkg::RAM_AW-1:0]] = acc.data;
                    r.ram_served                              = 1'b1;
                end
            end
            default: ;
        endcase

        pb = prg_q[3:0];
        case (control_q[3:2])
            slbm_pkg::PRG_MODE_32K_A, slbm_pkg::PRG_MODE_32K_B: begin
                r.prg_bank_8000 = {pb[3:1], 1'b0};
                r.prg_bank_c000 = {pb[3:1], 1'b1};
            end
            slbm_pkg::PRG_MODE_FIX_LO: begin
                r.prg_bank_8000 = 4'h0;
                r.prg_bank_c000 = pb;
            end
            default: begin
                r.prg_bank_8000 = pb;
                r.prg_bank_c000 = 4'hf;
            end
        endcase
        if (!chr_rom_fitted) begin
            r.chr_bank_0000 = 5'd0;
            r.chr_bank_1000 = 5'd1;
        end else if (control_q[4]) begin
            r.chr_bank_0000 = chr_low_q;
            r.chr_bank_1000 = chr_high_q;
        end else begin
            r.chr_bank_0000 = {chr_low_q[4:1], 1'b0};
            r.chr_bank_1000 = {chr_low_q[4:1], 1'b1};
        end
        r.mirroring = control_q[1:0];
        return r;
    endfunction

    // Driver: one transaction offered at a time, held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_res.push_back(map_access(on_bus));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_acc.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_acc.pop_front();
                    i_kind     <= on_bus.kind;
                    i_address  <= on_bus.addr;
                    i_data     <= on_bus.data;
                    i_cycle    <= on_bus.cyc;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fault_count++;
        end
    endtask

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        slbm_pkg::t_res want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_res.size() == 0) begin
                    $display("%0t: result with no transaction outstanding", $time);
                    fault_count++;
                end else begin
                    want = expected_res.pop_front();
                    results_seen++;
                    check_field("read_data", 32'(want.read_data), 32'(o_read_data));
                    check_field("ram_served", 32'(want.ram_served), 32'(o_ram_served));
                    check_field("write_ignored", 32'(want.write_ignored),
                                32'(o_write_ignored));
                    check_field("mirroring", 32'(want.mirroring), 32'(o_mirroring));
                    check_field("prg_bank_8000", 32'(want.prg_bank_8000),
                                32'(o_prg_bank_8000));
                    check_field("prg_bank_c000", 32'(want.prg_bank_c000),
                                32'(o_prg_bank_c000));
                    check_field("chr_bank_0000", 32'(want.chr_bank_0000),
                                32'(o_chr_bank_0000));
                    check_field("chr_bank_1000", 32'(want.chr_bank_1000),
                                32'(o_chr_bank_1000));
                end
            end
            i_out_stall <= long_hold || ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        tick_count <= tick_count + 1;
        if (tick_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     items_queued - results_seen);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Queue one access, advancing the CPU cycle count by gap first
    task automatic push_acc(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data, input logic [31:0] gap);
        cpu_cycle = cpu_cycle + gap;
        pending_acc.push_back('{kind, addr, data, cpu_cycle});
        items_queued++;
    endtask

    // Five spaced register writes, LSB first, committing value to the register at addr
    task automatic push_load(input logic [15:0] addr, input logic [4:0] value);
        logic [7:0] d;
        for (int i = 0; i < slbm_pkg::SHIFT_LEN; i++) begin
            d    = 8'($urandom);
            d[7] = 1'b0;
            d[0] = value[i];
            push_acc(slbm_pkg::KIND_REG_WRITE, addr, d, $urandom_range(2, 5));
        end
    endtask

    // Mostly well-formed register loads, with resets, too-close writes, RAM traffic and noise
    task automatic push_random_mix(input int target);
        int          counted;
        int          pick;
        logic [15:0] a;
        logic [4:0]  v;
        logic [1:0]  k;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            a    = 16'($urandom);
            if (pick < 40) begin
                v = 5'($urandom);
                // keep the RAM enabled most of the time
                if (a[14:13] == slbm_pkg::SEL_PRG) v[4] = ($urandom_range(3) == 0);
                push_load(a, v);
                counted += slbm_pkg::SHIFT_LEN;
            end else if (pick < 48) begin
                push_acc(slbm_pkg::KIND_REG_WRITE, a, 8'h80 | 8'($urandom),
                         $urandom_range(2, 6));
                counted++;
            end else if (pick < 58) begin
                push_acc(slbm_pkg::KIND_REG_WRITE, a, 8'($urandom), $urandom_range(2, 6));
                push_acc(slbm_pkg::KIND_REG_WRITE, 16'($urandom), 8'($urandom),
                         $urandom_range(0, 1));
                counted++;
            end else if (pick < 88) begin
                k = $urandom_range(1) ? slbm_pkg::KIND_RAM_WRITE : slbm_pkg::KIND_RAM_READ;
                // small address pool so reads find earlier writes
                if ($urandom_range(1)) begin
                    a[slbm_pkg::RAM_AW-1:0] = slbm_pkg::RAM_AW'($urandom_range(15));
                end
                push_acc(k, a, 8'($urandom), $urandom_range(0, 4));
                counted++;
            end else if (pick < 93) begin
                push_acc(KIND_UNUSED, a, 8'($urandom), $urandom_range(0, 4));
            end else begin
                // large jump of the cycle count, wrapping freely
                k = $urandom_range(1) ? slbm_pkg::KIND_REG_WRITE : slbm_pkg::KIND_RAM_READ;
                push_acc(k, a, 8'($urandom), $urandom);
                counted++;
            end
        end
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) @(posedge i_clk);
    endtask

    task automatic set_chr_rom(input logic fitted);
        @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_chr_rom <= fitted;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        chr_rom_fitted = fitted;
    endtask

    task automatic run_phase(input logic fitted, input int send_pct, input int stall_pct,
                             input bit hold_off);
        set_chr_rom(fitted);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        push_random_mix(MIX_TARGET);
        if (hold_off) begin
            // receiver holds off while the sender keeps offering, filling the block
            @(posedge i_clk);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            long_hold <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        foreach (ram_image[i]) ram_image[i] = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; items wait out the RAM clearing pass
        set_chr_rom(1'b1);
        push_acc(slbm_pkg::KIND_REG_WRITE, 16'h8000, 8'h00, 32'd0);  // early write at cycle 0
        push_acc(slbm_pkg::KIND_REG_WRITE, 16'h8000, 8'h01, 32'd1);  // early write, too close to the last one, ignored
        push_acc(slbm_pkg::KIND_REG_WRITE, 16'hffff, 8'h80, 32'd4);  // clear, PRG mode 3
        push_load(16'h9fff, 5'b10011);                     // 4K CHR, mode 0, horizontal
        push_load(16'h6000, 5'h1f);                        // PRG via address below 8000
        push_acc(slbm_pkg::KIND_RAM_READ, 16'h7fff, 8'h00, 32'd2);   // RAM disabled
        push_acc(slbm_pkg::KIND_RAM_WRITE, 16'h6000, 8'haa, 32'd2);
        push_load(16'he000, 5'h0a);                        // RAM back on
        push_acc(slbm_pkg::KIND_RAM_WRITE, 16'h7fff, 8'hff, 32'd2);
        push_acc(slbm_pkg::KIND_RAM_READ, 16'hffff, 8'h00, 32'd1);
        push_acc(KIND_UNUSED, 16'hffff, 8'hff, 32'd3);
        push_acc(slbm_pkg::KIND_REG_WRITE, 16'ha000, 8'h01, 32'hffff_ffff - cpu_cycle);
        push_acc(slbm_pkg::KIND_REG_WRITE, 16'ha000, 8'h00, 32'd2);  // gap across the wrap
        push_acc(slbm_pkg::KIND_REG_WRITE, 16'ha000, 8'h01, 32'd1);  // too close after the wrap
        wait_drained();

        run_phase(1'b1, 0, 0, 1'b1);
        run_phase(1'b0, 78, 0, 1'b0);
        run_phase(1'b1, 0, 78, 1'b0);
        run_phase(1'b0, 35, 35, 1'b0);

        repeat (10) @(posedge i_clk);
        if (expected_res.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_res.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
